[design/pagerank_power_iteration_defines.svh]
// Assertion macros of the PageRank block's RTL, used by prpi_dp.
// No dependencies; files that check their own logic include this header.
`ifndef PAGERANK_POWER_ITERATION_DEFINES_SVH
`define PAGERANK_POWER_ITERATION_DEFINES_SVH
`ifndef SYNTHESIS
`define PRPI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prpi: %m check failed");
`define PRPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prpi: %m check failed");
`else
`define PRPI_ASSERT_IMPL(label, ante, cons)
`define PRPI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/prpi_pkg.sv]
// Shared types, constants and helpers of the PageRank block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package prpi_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int EDGE_W    = $clog2(MAX_EDGES);
    localparam int ETOT_W    = $clog2(MAX_EDGES + 1);
    localparam int NCNT_W    = $clog2(MAX_NODES + 1);
    localparam int DEG_W     = ETOT_W;
    localparam int IN_NODE_W = 10;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int SCORE_W   = 32;
    localparam int D_W       = 16;
    localparam int ITER_W    = 8;
    localparam int PROD_W    = D_W + SCORE_W;
    localparam int DVND_W    = 48;
    localparam int DVSR_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [D_W-1:0]    DAMPING_RST = 16'd55706;
    localparam logic [ITER_W-1:0] ITER_RST    = 8'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_RUN      = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        logic             present;
        logic [DEG_W-1:0] deg;
    } t_node_ent;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_CLR_START,
        DP_CLR_STEP,
        DP_ADD_RD_SRC,
        DP_ADD_WR_SRC,
        DP_ADD_RD_TGT,
        DP_ADD_WR_TGT,
        DP_RD_ISSUE,
        DP_RESP,
        DP_DIV_INIT,
        DP_DIV_BASE,
        DP_SAVE_BASE,
        DP_NODE_START,
        DP_NODE_RD,
        DP_INIT_WR,
        DP_ND,
        DP_POOL,
        DP_DIV_CONTRIB,
        DP_WR_CONTRIB,
        DP_NODE_NEXT,
        DP_EDGE_START,
        DP_EDGE_RD,
        DP_EDGE_RD2,
        DP_EDGE_WR,
        DP_DIV_SHARE,
        DP_FIN_WR,
        DP_ROUND_INC
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status resp;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic add_oob;
        logic idx_oob;
        logic n_zero;
        logic node_last;
        logic node_present;
        logic node_dangling;
        logic edge_done;
        logic round_done;
        logic div_busy;
    } t_dp_stat;

    typedef enum logic [5:0] {
        S_CLR_INIT, S_CLR, S_IDLE,
        S_ADD_CHK, S_ADD_RS, S_ADD_WS, S_ADD_RT, S_ADD_WT,
        S_RD_ISSUE, S_RD_CHK,
        S_RUN_CHK, S_DIV_INIT, S_WAIT_INIT, S_INIT_START, S_INIT_RD, S_INIT_WR,
        S_DIV_BASE, S_WAIT_BASE, S_SAVE_BASE, S_ROUND_CHK,
        S_ND_START, S_ND_RD, S_ND, S_POOL, S_DIV_C, S_WAIT_C, S_WR_C, S_ND_NEXT,
        S_EDGE_START, S_EDGE_CHK, S_EDGE_RD, S_EDGE_RD2, S_EDGE_WR,
        S_DIV_SHARE, S_WAIT_S, S_FIN_START, S_FIN_RD, S_FIN_WR, S_ROUND_INC,
        S_RESP, S_OUT
    } t_state;

    // Unsigned add that sticks at all ones instead of wrapping.
    function automatic logic [SCORE_W-1:0] sat_add32(input logic [SCORE_W-1:0] a,
                                                     input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
    endfunction

endpackage
`default_nettype wire

[design/pagerank_power_iteration.sv]
// PageRank by the power method, one request at a time: each request holds the request
// side until its result has been taken with ready high.
// A run sweeps all M = 1024 node slots and the E stored edges in each of R rounds, and uses
// the 48-step divider for 1/N, the teleport term, each present node with edges and the
// dangling share. After reset a clearing pass over the node memory keeps the request ready
// low until it is done; configuration writes are taken.
`timescale 1ns / 1ps
`default_nettype none
module pagerank_power_iteration
    import prpi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel.
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [IN_NODE_W-1:0] i_src_node,
    input  wire logic [IN_NODE_W-1:0] i_tgt_node,
    input  wire logic [IN_NODE_W-1:0] i_node_index,
    // Result channel.
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [STAT_W-1:0]         o_status,
    output logic [NCNT_W-1:0]         o_node_count,
    output logic [SCORE_W-1:0]        o_score,
    output logic                      o_present,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    // The controller issues one datapath micro-operation per cycle and steers
    // by the status flags that come back. Each request gets exactly one result,
    // held in the datapath's output registers until the result is taken.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_st;

    prpi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_dp    (dp_cmd),
        .i_st    (dp_st)
    );

    // The datapath holds the graph (node and edge memories), the two score
    // buffers, the per-node contribution buffer and the shared divider that
    // forms 1/N, the teleport term, each node's per-edge share and the
    // dangling share.
    prpi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dp         (dp_cmd),
        .o_st         (dp_st),
        .i_cmd        (i_cmd),
        .i_src_node   (i_src_node),
        .i_tgt_node   (i_tgt_node),
        .i_node_index (i_node_index),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_status     (o_status),
        .o_node_count (o_node_count),
        .o_score      (o_score),
        .o_present    (o_present)
    );

endmodule
`default_nettype wire

[design/prpi_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on prpi_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module prpi_div
    import prpi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVND_W-1:0] i_dividend,
    input  wire logic [DVSR_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic [DVND_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(DVND_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_step;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [DVND_W-1:0] r_quot;
    logic [DVSR_W:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_quot[DVND_W-1]};
    assign ge    = trial >= {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == CNT_W'(DVND_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvsr <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= ge ? DVSR_W'(trial - {1'b0, r_dvsr}) : trial[DVSR_W-1:0];
            r_quot <= {r_quot[DVND_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

[design/prpi_ctrl.sv]
// Sequencing state machine of the PageRank block; drives the datapath by
// micro-operations. Depends on prpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prpi_ctrl
    import prpi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_dp_cmd               o_dp,
    input  wire t_dp_stat         i_st
);

    t_state  r_state, n_state;
    t_status r_resp, n_resp;
    logic    r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
            r_resp  <= STAT_OK;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
            r_reply <= n_reply;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_resp    = r_resp;
        n_reply   = r_reply;
        o_dp.op   = DP_NOP;
        o_dp.resp = r_resp;
        case (r_state)
            S_CLR_INIT: begin
                o_dp.op = DP_CLR_START;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_dp.op = DP_CLR_STEP;
                if (i_st.node_last) begin
                    n_resp  = STAT_OK;
                    n_state = r_reply ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_dp.op = DP_LATCH;
                    n_reply = 1'b1;
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR:    n_state = S_CLR_INIT;
                        CMD_ADD_EDGE: n_state = S_ADD_CHK;
                        CMD_RUN:      n_state = S_RUN_CHK;
                        CMD_READ:     n_state = S_RD_ISSUE;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_CHK: begin
                if (i_st.add_oob) begin
                    n_resp  = STAT_ABSENT;
                    n_state = S_RESP;
                end else if (i_st.full) begin
                    n_resp  = STAT_FULL;
                    n_state = S_RESP;
                end else begin
                    n_state = S_ADD_RS;
                end
            end
            S_ADD_RS: begin
                o_dp.op = DP_ADD_RD_SRC;
                n_state = S_ADD_WS;
            end
            S_ADD_WS: begin
                o_dp.op = DP_ADD_WR_SRC;
                n_state = S_ADD_RT;
            end
            S_ADD_RT: begin
                o_dp.op = DP_ADD_RD_TGT;
                n_state = S_ADD_WT;
            end
            S_ADD_WT: begin
                o_dp.op = DP_ADD_WR_TGT;
                n_resp  = STAT_OK;
                n_state = S_RESP;
            end
            S_RD_ISSUE: begin
                o_dp.op = DP_RD_ISSUE;
                n_state = S_RD_CHK;
            end
            S_RD_CHK: begin
                // Keep the read address on the node so the score is still there
                // when the result is captured.
                o_dp.op = DP_RD_ISSUE;
                n_resp  = (i_st.node_present && !i_st.idx_oob) ? STAT_OK : STAT_ABSENT;
                n_state = S_RESP;
            end
            S_RUN_CHK: begin
                n_resp  = STAT_OK;
                n_state = i_st.n_zero ? S_RESP : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_dp.op = DP_DIV_INIT;
                n_state = S_WAIT_INIT;
            end
            S_WAIT_INIT: begin
                if (!i_st.div_busy) begin
                    n_state = S_INIT_START;
                end
            end
            S_INIT_START: begin
                o_dp.op = DP_NODE_START;
                n_state = S_INIT_RD;
            end
            S_INIT_RD: begin
                o_dp.op = DP_NODE_RD;
                n_state = S_INIT_WR;
            end
            S_INIT_WR: begin
                o_dp.op = DP_INIT_WR;
                n_state = i_st.node_last ? S_DIV_BASE : S_INIT_RD;
            end
            S_DIV_BASE: begin
                o_dp.op = DP_DIV_BASE;
                n_state = S_WAIT_BASE;
            end
            S_WAIT_BASE: begin
                if (!i_st.div_busy) begin
                    n_state = S_SAVE_BASE;
                end
            end
            S_SAVE_BASE: begin
                o_dp.op = DP_SAVE_BASE;
                n_state = S_ROUND_CHK;
            end
            S_ROUND_CHK: begin
                n_resp  = STAT_OK;
                n_state = i_st.round_done ? S_RESP : S_ND_START;
            end
            S_ND_START: begin
                o_dp.op = DP_NODE_START;
                n_state = S_ND_RD;
            end
            S_ND_RD: begin
                o_dp.op = DP_NODE_RD;
                n_state = S_ND;
            end
            S_ND: begin
                o_dp.op = DP_ND;
                if (!i_st.node_present) begin
                    n_state = S_ND_NEXT;
                end else if (i_st.node_dangling) begin
                    n_state = S_POOL;
                end else begin
                    n_state = S_DIV_C;
                end
            end
            S_POOL: begin
                o_dp.op = DP_POOL;
                n_state = S_ND_NEXT;
            end
            S_DIV_C: begin
                o_dp.op = DP_DIV_CONTRIB;
                n_state = S_WAIT_C;
            end
            S_WAIT_C: begin
                if (!i_st.div_busy) begin
                    n_state = S_WR_C;
                end
            end
            S_WR_C: begin
                o_dp.op = DP_WR_CONTRIB;
                n_state = S_ND_NEXT;
            end
            S_ND_NEXT: begin
                o_dp.op = DP_NODE_NEXT;
                n_state = i_st.node_last ? S_EDGE_START : S_ND_RD;
            end
            S_EDGE_START: begin
                o_dp.op = DP_EDGE_START;
                n_state = S_EDGE_CHK;
            end
            S_EDGE_CHK: begin
                n_state = i_st.edge_done ? S_DIV_SHARE : S_EDGE_RD;
            end
            S_EDGE_RD: begin
                o_dp.op = DP_EDGE_RD;
                n_state = S_EDGE_RD2;
            end
            S_EDGE_RD2: begin
                o_dp.op = DP_EDGE_RD2;
                n_state = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                o_dp.op = DP_EDGE_WR;
                n_state = S_EDGE_CHK;
            end
            S_DIV_SHARE: begin
                o_dp.op = DP_DIV_SHARE;
                n_state = S_WAIT_S;
            end
            S_WAIT_S: begin
                if (!i_st.div_busy) begin
                    n_state = S_FIN_START;
                end
            end
            S_FIN_START: begin
                o_dp.op = DP_NODE_START;
                n_state = S_FIN_RD;
            end
            S_FIN_RD: begin
                o_dp.op = DP_NODE_RD;
                n_state = S_FIN_WR;
            end
            S_FIN_WR: begin
                o_dp.op = DP_FIN_WR;
                n_state = i_st.node_last ? S_ROUND_INC : S_FIN_RD;
            end
            S_ROUND_INC: begin
                o_dp.op = DP_ROUND_INC;
                n_state = S_ROUND_CHK;
            end
            S_RESP: begin
                o_dp.op = DP_RESP;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule
`default_nettype wire

[design/prpi_dp.sv]
// Datapath of the PageRank block: node, edge and score memories, counters,
// multiplier, shared divider and configuration registers. Depends on prpi_pkg,
// prpi_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "pagerank_power_iteration_defines.svh"
module prpi_dp
    import prpi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_dp,
    output t_dp_stat                  o_st,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [IN_NODE_W-1:0] i_src_node,
    input  wire logic [IN_NODE_W-1:0] i_tgt_node,
    input  wire logic [IN_NODE_W-1:0] i_node_index,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic [STAT_W-1:0]         o_status,
    output logic [NCNT_W-1:0]         o_node_count,
    output logic [SCORE_W-1:0]        o_score,
    output logic                      o_present
);

    // Configuration and request fields.
    logic [D_W-1:0]       r_damping;
    logic [ITER_W-1:0]    r_iters;
    t_cmd                 r_cmd_q;
    logic [IN_NODE_W-1:0] r_src, r_tgt, r_idx;

    // Graph totals and sweep counters.
    logic [ETOT_W-1:0] r_edge_total;
    logic [NCNT_W-1:0] r_present_total;
    logic [NODE_W-1:0] r_cnt;
    logic [ETOT_W-1:0] r_ecnt;
    logic [ITER_W-1:0] r_round;

    logic [SCORE_W-1:0] r_base;
    logic [PROD_W-1:0]  r_pool;
    logic [PROD_W-1:0]  r_prod;
    logic [NODE_W-1:0]  r_tq;

    t_status            r_status;
    logic [SCORE_W-1:0] r_score;
    logic               r_pres;

    // Memories and their registered read data.
    t_node_ent           r_node_mem [MAX_NODES];
    logic [2*NODE_W-1:0] r_edge_mem [MAX_EDGES];
    logic [SCORE_W-1:0]  r_now_mem  [MAX_NODES];
    logic [SCORE_W-1:0]  r_next_mem [MAX_NODES];
    logic [SCORE_W-1:0]  r_ctb_mem  [MAX_NODES];
    t_node_ent           r_node_q;
    logic [2*NODE_W-1:0] r_edge_q;
    logic [SCORE_W-1:0]  r_now_q, r_next_q, r_ctb_q;

    logic                node_we;
    logic [NODE_W-1:0]   node_wa, node_ra;
    t_node_ent           node_wd;
    logic                edge_we;
    logic                now_we;
    logic [NODE_W-1:0]   now_wa, now_ra;
    logic [SCORE_W-1:0]  now_wd;
    logic                next_we;
    logic [NODE_W-1:0]   next_wa, next_ra;
    logic [SCORE_W-1:0]  next_wd;
    logic                ctb_we;
    logic [NODE_W-1:0]   e_src, e_tgt;

    logic                div_start, div_busy;
    logic [DVND_W-1:0]   div_dvnd, div_q;
    logic [DVSR_W-1:0]   div_dvsr;
    logic [SCORE_W-1:0]  q32;

    assign e_src = r_edge_q[2*NODE_W-1:NODE_W];
    assign e_tgt = r_edge_q[NODE_W-1:0];
    assign q32   = div_q[SCORE_W-1:0];

    prpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvnd),
        .i_divisor  (div_dvsr),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    always_comb begin
        div_start = 1'b0;
        div_dvnd  = '0;
        div_dvsr  = DVSR_W'(r_present_total);
        case (i_dp.op)
            DP_DIV_INIT: begin
                div_start = 1'b1;
                div_dvnd  = DVND_W'(64'h8000_0000);
            end
            DP_DIV_BASE: begin
                div_start = 1'b1;
                div_dvnd  = DVND_W'({(17'h10000 - {1'b0, r_damping}), 15'b0});
            end
            DP_DIV_CONTRIB: begin
                div_start = 1'b1;
                div_dvnd  = DVND_W'(r_prod);
                div_dvsr  = DVSR_W'({r_node_q.deg, 16'b0});
            end
            DP_DIV_SHARE: begin
                div_start = 1'b1;
                div_dvnd  = DVND_W'(r_pool);
                div_dvsr  = DVSR_W'({r_present_total, 16'b0});
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Memory port selection.
    always_comb begin
        node_we = 1'b0;
        node_wa = r_cnt;
        node_wd = '0;
        node_ra = r_cnt;
        edge_we = 1'b0;
        now_we  = 1'b0;
        now_wa  = r_cnt;
        now_wd  = q32;
        now_ra  = r_cnt;
        next_we = 1'b0;
        next_wa = r_cnt;
        next_wd = r_base;
        next_ra = r_cnt;
        ctb_we  = 1'b0;
        case (i_dp.op)
            DP_CLR_STEP: begin
                node_we = 1'b1;
            end
            DP_ADD_RD_SRC: begin
                node_ra = NODE_W'(r_src);
            end
            DP_ADD_WR_SRC: begin
                node_we         = 1'b1;
                node_wa         = NODE_W'(r_src);
                node_wd.present = 1'b1;
                node_wd.deg     = r_node_q.deg + 1'b1;
                edge_we         = 1'b1;
            end
            DP_ADD_RD_TGT: begin
                node_ra = NODE_W'(r_tgt);
            end
            DP_ADD_WR_TGT: begin
                node_we         = !r_node_q.present;
                node_wa         = NODE_W'(r_tgt);
                node_wd.present = 1'b1;
                node_wd.deg     = r_node_q.deg;
            end
            DP_RD_ISSUE: begin
                node_ra = NODE_W'(r_idx);
                now_ra  = NODE_W'(r_idx);
            end
            DP_INIT_WR: begin
                now_we = r_node_q.present;
            end
            DP_ND: begin
                next_we = r_node_q.present;
            end
            DP_WR_CONTRIB: begin
                ctb_we = 1'b1;
            end
            DP_EDGE_RD2: begin
                next_ra = e_tgt;
            end
            DP_EDGE_WR: begin
                next_we = 1'b1;
                next_wa = r_tq;
                next_wd = sat_add32(r_next_q, r_ctb_q);
            end
            DP_FIN_WR: begin
                now_we = r_node_q.present;
                now_wd = sat_add32(r_next_q, q32);
            end
            default: begin
                node_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_wa] <= node_wd;
        end
        r_node_q <= r_node_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[r_edge_total[EDGE_W-1:0]] <= {NODE_W'(r_src), NODE_W'(r_tgt)};
        end
        r_edge_q <= r_edge_mem[r_ecnt[EDGE_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (now_we) begin
            r_now_mem[now_wa] <= now_wd;
        end
        r_now_q <= r_now_mem[now_ra];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        r_next_q <= r_next_mem[next_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ctb_we) begin
            r_ctb_mem[r_cnt] <= q32;
        end
        r_ctb_q <= r_ctb_mem[e_src];
    end

    // Control registers: configuration, totals and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping       <= DAMPING_RST;
            r_iters         <= ITER_RST;
            r_edge_total    <= '0;
            r_present_total <= '0;
            r_cnt           <= '0;
            r_ecnt          <= '0;
            r_round         <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DAMPING) begin
                    r_damping <= i_cfg_data[D_W-1:0];
                end else if (i_cfg_index == CFG_ITERATIONS) begin
                    r_iters <= i_cfg_data[ITER_W-1:0];
                end
            end
            case (i_dp.op)
                DP_CLR_START: begin
                    r_cnt           <= '0;
                    r_edge_total    <= '0;
                    r_present_total <= '0;
                end
                DP_CLR_STEP, DP_INIT_WR, DP_FIN_WR, DP_NODE_NEXT: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                DP_ADD_WR_SRC: begin
                    r_edge_total <= r_edge_total + 1'b1;
                    if (!r_node_q.present) begin
                        r_present_total <= r_present_total + 1'b1;
                    end
                end
                DP_ADD_WR_TGT: begin
                    if (!r_node_q.present) begin
                        r_present_total <= r_present_total + 1'b1;
                    end
                end
                DP_NODE_START: begin
                    r_cnt <= '0;
                end
                DP_SAVE_BASE: begin
                    r_round <= '0;
                end
                DP_ROUND_INC: begin
                    r_round <= r_round + 1'b1;
                end
                DP_EDGE_START: begin
                    r_ecnt <= '0;
                end
                DP_EDGE_WR: begin
                    r_ecnt <= r_ecnt + 1'b1;
                end
                default: begin
                    r_round <= r_round;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_dp.op)
            DP_LATCH: begin
                r_cmd_q <= t_cmd'(i_cmd);
                r_src   <= i_src_node;
                r_tgt   <= i_tgt_node;
                r_idx   <= i_node_index;
            end
            DP_SAVE_BASE: begin
                r_base <= q32;
            end
            DP_NODE_START: begin
                r_pool <= '0;
            end
            DP_ND: begin
                r_prod <= r_damping * r_now_q;
            end
            DP_POOL: begin
                r_pool <= r_pool + r_prod;
            end
            DP_EDGE_RD2: begin
                r_tq <= e_tgt;
            end
            DP_RESP: begin
                r_status <= i_dp.resp;
                if (r_cmd_q == CMD_READ && i_dp.resp == STAT_OK) begin
                    r_score <= r_now_q;
                    r_pres  <= 1'b1;
                end else begin
                    r_score <= '0;
                    r_pres  <= 1'b0;
                end
            end
            default: begin
                r_tq <= r_tq;
            end
        endcase
    end

    always_comb begin
        o_st.full          = (r_edge_total == ETOT_W'(MAX_EDGES));
        o_st.add_oob       = (32'(r_src) >= 32'(MAX_NODES)) || (32'(r_tgt) >= 32'(MAX_NODES));
        o_st.idx_oob       = (32'(r_idx) >= 32'(MAX_NODES));
        o_st.n_zero        = (r_present_total == '0);
        o_st.node_last     = (r_cnt == NODE_W'(MAX_NODES - 1));
        o_st.node_present  = r_node_q.present;
        o_st.node_dangling = (r_node_q.deg == '0);
        o_st.edge_done     = (r_ecnt == r_edge_total);
        o_st.round_done    = (r_round == r_iters);
        o_st.div_busy      = div_busy;
    end

    assign o_cfg_ready  = 1'b1;
    assign o_status     = r_status;
    assign o_node_count = r_present_total;
    assign o_score      = r_score;
    assign o_present    = r_pres;

    `PRPI_ASSERT_IMPL(a_edge_total_bound, 1'b1, r_edge_total <= ETOT_W'(MAX_EDGES))
    `PRPI_ASSERT_IMPL(a_div_start_idle, div_start, !div_busy)
    `PRPI_ASSERT_NEXT(a_edge_step, i_dp.op == DP_EDGE_WR, r_ecnt == ETOT_W'($past(r_ecnt) + 1'b1))

endmodule
`default_nettype wire

[tb/sv/pagerank_power_iteration_tb.sv]
// Self-checking testbench for the PageRank power-method block: a directed table, then
// random graphs with runs and reads, checked against typed results or an in-bench predictor.
// Depends on prpi_pkg and pagerank_power_iteration.
`timescale 1ns / 1ps
module pagerank_power_iteration_tb;
    import prpi_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int RANDOM_REQUESTS = 650;

    // One row of stimulus. When known is set, the expected result is typed in the row;
    // otherwise it comes from the predictor.
    typedef struct {
        t_cmd        cmd;
        logic [9:0]  src;
        logic [9:0]  tgt;
        logic [9:0]  idx;
        bit          known;
        t_status     st;
        logic [10:0] cnt;
        logic [31:0] sc;
        bit          pr;
    } t_row;

    typedef struct {
        t_status     st;
        logic [10:0] cnt;
        logic [31:0] sc;
        bit          pr;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [9:0]  i_src_node;
    logic [9:0]  i_tgt_node;
    logic [9:0]  i_node_index;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [10:0] o_node_count;
    logic [31:0] o_score;
    logic        o_present;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    pagerank_power_iteration dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(i_cmd),
        .i_src_node(i_src_node), .i_tgt_node(i_tgt_node), .i_node_index(i_node_index),
        .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
        .o_node_count(o_node_count), .o_score(o_score), .o_present(o_present),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state: the graph, the scores and the two registers as the bench sees them.
    bit              node_on[1024];
    bit              node_scored[1024];
    int unsigned     node_deg[1024];
    logic [9:0]      edge_from[4096];
    logic [9:0]      edge_to[4096];
    int unsigned     edges_held;
    int unsigned     nodes_held;
    longint unsigned score_now[1024];
    longint unsigned score_nxt[1024];
    logic [15:0]     damp_reg;
    logic [7:0]      rounds_reg;

    t_answer pending_answers[$];
    logic [9:0] empty_pool[$];
    int      errors;
    int      cycles;
    int      rx_hold;
    int      rx_burst;
    bit      quiet;
    int      random_sent;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The whole test ends with an error once it runs past the overall cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned sat32(input longint unsigned a,
                                              input longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    // Power iteration over the present nodes, dangling mass pooled once per round.
    function automatic void rank_graph();
        longint unsigned n, d, base, pool, share;
        int unsigned s, t;
        n = 64'(nodes_held);
        d = 64'(damp_reg);
        if (n == 0) return;
        for (int i = 0; i < 1024; i++)
            if (node_on[i]) begin
                score_now[i] = 64'h8000_0000 / n;
                node_scored[i] = 1'b1;
            end
        for (int r = 0; r < int'(rounds_reg); r++) begin
            base = ((64'd65536 - d) << 15) / n;
            pool = 0;
            for (int i = 0; i < 1024; i++)
                if (node_on[i]) begin
                    score_nxt[i] = base;
                    if (node_deg[i] == 0) pool += d * score_now[i];
                end
            for (int e = 0; e < int'(edges_held); e++) begin
                s = 32'(edge_from[e]);
                t = 32'(edge_to[e]);
                if (node_deg[s] != 0)
                    score_nxt[t] = sat32(score_nxt[t],
                                         d * score_now[s] / (64'd65536 * 64'(node_deg[s])));
            end
            share = pool / (64'd65536 * n);
            for (int i = 0; i < 1024; i++)
                if (node_on[i]) score_now[i] = sat32(score_nxt[i], share);
        end
    endfunction

    function automatic void mark_node(input logic [9:0] n);
        if (!node_on[n]) begin
            node_on[n] = 1'b1;
            nodes_held++;
        end
    endfunction

    // Appends one expected result at the tail of the list.
    function automatic void queue_answer(input t_answer a);
        pending_answers.insert(pending_answers.size(), a);
    endfunction

    // Updates the predictor for one accepted request and returns its answer.
    function automatic t_answer predict_answer(input t_row rq);
        t_answer a;
        a = '{STAT_OK, 11'd0, 32'd0, 1'b0};
        case (rq.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < 1024; i++) begin
                    node_on[i] = 1'b0;
                    node_deg[i] = 0;
                end
                edges_held = 0;
                nodes_held = 0;
            end
            CMD_ADD_EDGE: begin
                if (edges_held >= 4096) begin
                    a.st = STAT_FULL;
                end else begin
                    edge_from[edges_held] = rq.src;
                    edge_to[edges_held] = rq.tgt;
                    edges_held++;
                    node_deg[rq.src]++;
                    mark_node(rq.src);
                    mark_node(rq.tgt);
                end
            end
            CMD_RUN: rank_graph();
            default: begin
                if (node_on[rq.idx]) begin
                    a.pr = 1'b1;
                    a.sc = score_now[rq.idx][31:0];
                end else begin
                    a.st = STAT_ABSENT;
                end
            end
        endcase
        a.cnt = nodes_held[10:0];
        return a;
    endfunction

    // Result side: compare each accepted result with the oldest expectation, and
    // hold ready low in random bursts or for a requested long stretch.
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result status=%0d count=%0d", $time,
                         o_status, o_node_count);
                errors++;
            end else begin
                w = pending_answers.pop_front();
                if (o_status !== w.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, w.st, o_status);
                    errors++;
                end
                if (o_node_count !== w.cnt) begin
                    $display("%0t: node_count expected %0d actual %0d", $time, w.cnt,
                             o_node_count);
                    errors++;
                end
                if (o_score !== w.sc) begin
                    $display("%0t: score expected %h actual %h", $time, w.sc, o_score);
                    errors++;
                end
                if (o_present !== w.pr) begin
                    $display("%0t: present expected %0d actual %0d", $time, w.pr, o_present);
                    errors++;
                end
            end
        end
        if (rx_hold > 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_burst > 0) begin
            i_ready <= 1'b0;
            rx_burst <= rx_burst - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            i_ready <= 1'b0;
            rx_burst <= int'($urandom_range(0, 8));
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Offers one request and waits for it to be taken. Valid stays high afterwards, so
    // the caller either sends the next request in the same step or calls drop_request.
    task automatic send_row(input t_row rq);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 9)) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= rq.cmd;
        i_src_node   <= rq.src;
        i_tgt_node   <= rq.tgt;
        i_node_index <= rq.idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (rq.known) begin
            void'(predict_answer(rq));
            queue_answer(t_answer'{rq.st, rq.cnt, rq.sc, rq.pr});
        end else begin
            queue_answer(predict_answer(rq));
        end
    endtask

    task automatic send_request(input t_cmd c, input logic [9:0] s, input logic [9:0] t,
                                input logic [9:0] x);
        send_row('{c, s, t, x, 1'b0, STAT_OK, 11'd0, 32'd0, 1'b0});
    endtask

    task automatic drop_request();
        i_valid <= 1'b0;
    endtask

    // Sender pause: drop valid, let every expected result arrive, then idle before returning.
    task automatic drain_results();
        drop_request();
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == CFG_DAMPING) damp_reg = data;
        else rounds_reg = data[7:0];
    endtask

    // A read of a present node that no run has scored is never issued.
    function automatic logic [9:0] pick_read_node(input logic [9:0] pool[$]);
        logic [9:0] n;
        if (pool.size() != 0 && $urandom_range(0, 3) != 0)
            n = pool[$urandom_range(0, pool.size() - 1)];
        else
            n = 10'($urandom_range(0, 1023));
        while (node_on[n] && !node_scored[n]) n = 10'($urandom_range(0, 1023));
        return n;
    endfunction

    // Loads a random graph over a small node pool, runs it and reads scores back.
    task automatic graph_round(input int n_edges, input int n_reads, input int pool_size);
        logic [9:0] pool[$];
        logic [9:0] s, t;
        for (int i = 0; i < pool_size; i++)
            pool.insert(pool.size(), 10'($urandom_range(0, 1023)));
        for (int i = 0; i < n_edges; i++) begin
            s = pool[$urandom_range(0, pool_size - 1)];
            t = pool[$urandom_range(0, pool_size - 1)];
            if ($urandom_range(0, 9) == 0) t = 10'($urandom_range(0, 1023));
            send_request(CMD_ADD_EDGE, s, t, 10'($urandom_range(0, 1023)));
            random_sent++;
        end
        send_request(CMD_RUN, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)));
        random_sent++;
        for (int i = 0; i < n_reads; i++) begin
            send_request(CMD_READ, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         pick_read_node(pool));
            random_sent++;
        end
    endtask

    t_row directed_rows[$];

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cmd = CMD_CLEAR;
        i_src_node = '0;
        i_tgt_node = '0;
        i_node_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DAMPING;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        rx_hold = 0;
        rx_burst = 0;
        quiet = 1'b0;
        random_sent = 0;
        edges_held = 0;
        nodes_held = 0;
        damp_reg = DAMPING_RST;
        rounds_reg = ITER_RST;
        for (int i = 0; i < 1024; i++) begin
            node_on[i] = 1'b0;
            node_scored[i] = 1'b0;
            node_deg[i] = 0;
        end

        // Directed part, run with the registers at their reset values: reads of an empty
        // graph, a run on an empty graph, the corner node indices, a self loop, a
        // duplicate edge, a dangling node, and a stale score after a later edge.
        directed_rows = '{
            '{CMD_READ,     10'd0,    10'd0,   10'd0,    1'b1, STAT_ABSENT, 11'd0, 32'd0, 1'b0},
            '{CMD_RUN,      10'd1023, 10'd1023, 10'd1023, 1'b1, STAT_OK,   11'd0, 32'd0, 1'b0},
            '{CMD_ADD_EDGE, 10'd1023, 10'd0,   10'd0,    1'b1, STAT_OK,     11'd2, 32'd0, 1'b0},
            '{CMD_ADD_EDGE, 10'd0,    10'd0,   10'd0,    1'b1, STAT_OK,     11'd2, 32'd0, 1'b0},
            '{CMD_ADD_EDGE, 10'd1023, 10'd0,   10'd0,    1'b1, STAT_OK,     11'd2, 32'd0, 1'b0},
            '{CMD_ADD_EDGE, 10'd5,    10'd7,   10'd0,    1'b1, STAT_OK,     11'd4, 32'd0, 1'b0},
            '{CMD_ADD_EDGE, 10'd682,  10'd341, 10'd0,    1'b1, STAT_OK,     11'd6, 32'd0, 1'b0},
            '{CMD_RUN,      10'd0,    10'd0,   10'd0,    1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd1023, 1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd0,    1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd5,    1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd7,    1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd682,  1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd341,  1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd6,    1'b1, STAT_ABSENT, 11'd6, 32'd0, 1'b0},
            '{CMD_ADD_EDGE, 10'd7,    10'd5,   10'd0,    1'b1, STAT_OK,     11'd6, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd7,    1'b0, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_CLEAR,    10'd0,    10'd0,   10'd0,    1'b1, STAT_OK,     11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd0,    1'b1, STAT_ABSENT, 11'd0, 32'd0, 1'b0},
            '{CMD_READ,     10'd0,    10'd0,   10'd1023, 1'b1, STAT_ABSENT, 11'd0, 32'd0, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its node memory after reset; the first request simply
        // waits for ready.
        foreach (directed_rows[i]) send_row(directed_rows[i]);
        drain_results();

        // Zero rounds with no damping: every score stays at its starting share.
        write_register(CFG_ITERATIONS, 16'd0);
        write_register(CFG_DAMPING, 16'd0);
        graph_round(6, 4, 4);
        drain_results();

        // Full damping over the largest round count, on a graph over a two-node pool to keep it short.
        write_register(CFG_DAMPING, 16'hFFFF);
        write_register(CFG_ITERATIONS, 16'd255);
        send_request(CMD_CLEAR, 10'd0, 10'd0, 10'd0);
        graph_round(2, 3, 2);
        drain_results();

        // Back pressure: results are held off for a long stretch while requests keep
        // coming, so the block stalls its request side.
        write_register(CFG_ITERATIONS, 16'd1);
        write_register(CFG_DAMPING, DAMPING_RST);
        rx_hold = 400;
        graph_round(4, 8, 3);
        drain_results();

        // Random part: mostly well-formed load, run and read sequences, with some clears
        // and stray reads between them. The tail runs without random request gaps or ready holds.
        while (random_sent < RANDOM_REQUESTS) begin
            if (random_sent > RANDOM_REQUESTS - 100) quiet = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
                case ($urandom_range(0, 3))
                    0: write_register(CFG_DAMPING, 16'd0);
                    1: write_register(CFG_DAMPING, 16'hFFFF);
                    default: write_register(CFG_DAMPING, 16'($urandom_range(0, 65535)));
                endcase
                write_register(CFG_ITERATIONS,
                               ($urandom_range(0, 9) == 0) ? 16'd20
                                                           : 16'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 2) == 0) begin
                send_request(CMD_CLEAR, 10'($urandom_range(0, 1023)),
                             10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
                random_sent++;
            end
            for (int i = int'($urandom_range(0, 2)); i > 0; i--) begin
                send_request(CMD_READ, 10'($urandom_range(0, 1023)),
                             10'($urandom_range(0, 1023)), pick_read_node(empty_pool));
                random_sent++;
            end
            graph_round(int'($urandom_range(1, 24)), int'($urandom_range(3, 12)),
                        int'($urandom_range(2, 12)));
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
